// ===== hdl/obsz_pkg.sv =====
`timescale 1ns / 1ps

package obsz_pkg;

  // sweep geometry
  localparam logic [15:0] PosQuarter = 16'd4096;
  localparam logic [15:0] PosTurn    = 16'd8192;
  localparam logic [15:0] PosStop    = 16'd12288;
  localparam logic [16:0] ZoomHalf   = 17'd2048;
  localparam logic [15:0] QuotMax    = 16'hFFFF;

  // divider
  localparam int unsigned DivSteps = 16;
  localparam int unsigned CntW     = $clog2(DivSteps);

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 13;
  localparam logic [CfgIdxW-1:0] CfgScanTime  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgZoom      = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgButtonLag = 2'd2;

  // input kinds
  localparam logic KindTick  = 1'b0;
  localparam logic KindPress = 1'b1;

  // controller states
  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StPrep = 4'b0010,
    StDiv  = 4'b0100,
    StFin  = 4'b1000
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic prep;
    logic div_step;
    logic finish;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic active;
    logic sat;
    logic out_free;
  } dp_sts_t;

  // zoom factor clamped to 1..16
  function automatic logic [4:0] zoom_clamp(input logic [4:0] z);
    logic [4:0] r;
    r = z;
    if (z == 5'd0) r = 5'd1;
    else if (z > 5'd16) r = 5'd16;
    return r;
  endfunction

  // 2048 / z for z in 1..16
  function automatic logic [11:0] zoom_in_half(input logic [4:0] z);
    logic [11:0] r;
    unique case (z)
      5'd1:    r = 12'd2048;
      5'd2:    r = 12'd1024;
      5'd3:    r = 12'd682;
      5'd4:    r = 12'd512;
      5'd5:    r = 12'd409;
      5'd6:    r = 12'd341;
      5'd7:    r = 12'd292;
      5'd8:    r = 12'd256;
      5'd9:    r = 12'd227;
      5'd10:   r = 12'd204;
      5'd11:   r = 12'd186;
      5'd12:   r = 12'd170;
      5'd13:   r = 12'd157;
      5'd14:   r = 12'd146;
      5'd15:   r = 12'd136;
      default: r = 12'd128;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/obsz_intf.sv =====
`timescale 1ns / 1ps

// input items: timer ticks and button presses
interface obsz_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] time_ms;
  modport source (output valid, kind, time_ms, input ready);
  modport sink (input valid, kind, time_ms, output ready);
endinterface

// result items
interface obsz_out_if;
  logic               valid;
  logic               ready;
  logic               scanning;
  logic [12:0]        marker_location;
  logic               zoom_valid;
  logic signed [16:0] zoom_low;
  logic signed [16:0] zoom_high;
  modport source (output valid, scanning, marker_location, zoom_valid, zoom_low,
                  zoom_high, input ready);
  modport sink (input valid, scanning, marker_location, zoom_valid, zoom_low,
                zoom_high, output ready);
endinterface

// configuration writes
interface obsz_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  wr_index;
  logic [12:0] wr_data;
  modport source (output valid, wr_index, wr_data, input ready);
  modport sink (input valid, wr_index, wr_data, output ready);
endinterface

// ===== hdl/obsz_ctrl.sv =====
`timescale 1ns / 1ps

module obsz_ctrl
  import obsz_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o
);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = StPrep;
        end
      end
      StPrep: begin
        cmd_o.prep = 1'b1;
        cnt_d = '0;
        state_d = sts_i.active ? StDiv : StFin;
      end
      StDiv: begin
        // saturated quotient needs no division
        if (sts_i.sat) begin
          state_d = StFin;
        end else begin
          cmd_o.div_step = 1'b1;
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == CntW'(DivSteps - 1)) state_d = StFin;
        end
      end
      StFin: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== hdl/obsz_dp.sv =====
`timescale 1ns / 1ps

module obsz_dp
  import obsz_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        kind_i,
  input  logic [31:0] time_ms_i,
  input  ctrl_cmd_t   cmd_i,
  output dp_sts_t     sts_o,
  obsz_cfg_if.sink    cfg_i,
  obsz_out_if.source  out_o
);

  // configuration registers
  logic [12:0] scan_q;
  logic [4:0]  zoom_q;
  logic [9:0]  lag_q;

  // sweep state
  logic        active_q, active_d;
  logic [31:0] start_q, start_d;
  logic [12:0] pos_q, pos_d;

  // captured item and divider
  logic        kind_q;
  logic [31:0] time_q;
  logic        sat_q;
  logic [12:0] rem_q;
  logic [15:0] shf_q;

  // result register
  logic               ov_q;
  logic               o_scan_q;
  logic [12:0]        o_pos_q;
  logic               o_zv_q;
  logic [16:0]        o_lo_q;
  logic [16:0]        o_hi_q;

  logic [31:0] elapsed;
  logic [31:0] lagged;
  logic [31:0] operand;
  logic [31:0] sat_limit;
  logic [13:0] trial;
  logic [13:0] diff;
  logic        ge;
  logic [15:0] quot;
  logic [15:0] fold16;
  logic [12:0] fold;
  logic [4:0]  zeff;
  logic [11:0] half_in;
  logic [16:0] span_out;
  logic        zv;
  logic [16:0] lo, hi;

  assign cfg_i.ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= 13'd100;
      zoom_q <= 5'd1;
      lag_q  <= 10'd25;
    end else if (cfg_i.valid) begin
      priority if (cfg_i.wr_index == CfgScanTime) begin
        scan_q <= cfg_i.wr_data;
      end else if (cfg_i.wr_index == CfgZoom) begin
        zoom_q <= cfg_i.wr_data[4:0];
      end else if (cfg_i.wr_index == CfgButtonLag) begin
        lag_q <= cfg_i.wr_data[9:0];
      end
    end
  end

  // elapsed time, lag clamped at zero, saturation test
  always_comb begin
    elapsed   = time_q - start_q;
    lagged    = (elapsed > {22'd0, lag_q}) ? elapsed - {22'd0, lag_q} : 32'd0;
    operand   = (kind_q == KindPress) ? lagged : elapsed;
    sat_limit = {15'd0, scan_q, 4'd0};
  end

  // one restoring division step
  always_comb begin
    trial = {rem_q, shf_q[15]};
    diff  = trial - {1'b0, scan_q};
    ge    = trial >= {1'b0, scan_q};
  end

  // item capture and divider registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      time_q <= time_ms_i;
    end
    if (cmd_i.prep) begin
      sat_q <= operand >= sat_limit;
      rem_q <= operand[16:4];
      shf_q <= {operand[3:0], 12'd0};
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? diff[12:0] : trial[12:0];
      shf_q <= {shf_q[14:0], ge};
    end
  end

  // position, fold and zoom interval
  always_comb begin
    quot     = sat_q ? QuotMax : shf_q;
    fold16   = (quot > PosQuarter) ? PosTurn - quot : quot;
    fold     = fold16[12:0];
    zeff     = zoom_clamp(zoom_q);
    half_in  = zoom_in_half(zeff);
    span_out = {1'b0, zeff, 11'd0};
    active_d = active_q;
    start_d  = start_q;
    pos_d    = pos_q;
    zv       = 1'b0;
    lo       = '0;
    hi       = '0;
    if (kind_q == KindTick) begin
      if (active_q) begin
        if (quot > PosTurn) begin
          if (quot > PosStop) active_d = 1'b0;
          pos_d = '0;
        end else begin
          pos_d = fold;
        end
      end
    end else if (active_q) begin
      zv       = 1'b1;
      active_d = 1'b0;
      if (quot > PosTurn) begin
        lo    = ZoomHalf - span_out;
        hi    = ZoomHalf + span_out;
        pos_d = '0;
      end else begin
        lo    = {4'd0, fold} - {5'd0, half_in};
        hi    = {4'd0, fold} + {5'd0, half_in};
        pos_d = fold;
      end
    end else begin
      active_d = 1'b1;
      start_d  = time_q;
    end
  end

  // sweep state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      start_q  <= '0;
      pos_q    <= '0;
    end else if (cmd_i.finish) begin
      active_q <= active_d;
      start_q  <= start_d;
      pos_q    <= pos_d;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.finish) begin
      ov_q <= 1'b1;
    end else if (out_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      o_scan_q <= active_d;
      o_pos_q  <= pos_d;
      o_zv_q   <= zv;
      o_lo_q   <= lo;
      o_hi_q   <= hi;
    end
  end

  assign out_o.valid           = ov_q;
  assign out_o.scanning        = o_scan_q;
  assign out_o.marker_location = o_pos_q;
  assign out_o.zoom_valid      = o_zv_q;
  assign out_o.zoom_low        = $signed(o_lo_q);
  assign out_o.zoom_high       = $signed(o_hi_q);

  assign sts_o.active   = active_q;
  assign sts_o.sat      = sat_q;
  assign sts_o.out_free = !ov_q || out_o.ready;

endmodule

// ===== hdl/one_button_scan_zoom_top.sv =====
// single-switch scanning controller
// in_i carries timer ticks (kind 0) and button presses (kind 1) with the
// current time in ms; every item gives exactly one result on out_o.
// cfg_i writes scan time (index 0), zoom factor (index 1) and button lag
// (index 2); it is always ready; the user must write it only while the block
// is idle, as the block does not enforce this. without a sweep an item goes
// through capture, prep and finish; a saturated position skips the divider;
// otherwise a restoring divider gives the position quotient, one bit per cycle.
// the block works on one item at a time; in_i.ready is high only between items.
// results sit in an output register, so the next item is taken while a result
// still waits; if the receiver stalls, the following item waits at its last
// step until the register frees up.
// reset clears the sweep state and loads the register defaults
// (scan time 100, zoom 1, lag 25); out_o.valid is low after reset.
`timescale 1ns / 1ps

module one_button_scan_zoom_top
  import obsz_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  obsz_in_if.sink    in_i,
  obsz_out_if.source out_o,
  obsz_cfg_if.sink   cfg_i
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // sequencer
  obsz_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // divider, sweep state and result register
  obsz_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .kind_i    (in_i.kind),
    .time_ms_i (in_i.time_ms),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .cfg_i     (cfg_i),
    .out_o     (out_o)
  );

endmodule

// ===== tb/obsz_checker.sv =====
`timescale 1ns / 1ps

// watches the item, result and register channels, predicts every result of
// the scanning controller and compares it field by field
module obsz_checker
  import obsz_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  obsz_in_if          item_i,
  obsz_out_if         result_i,
  obsz_cfg_if         cfg_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic               scanning;
    logic [12:0]        marker;
    logic               zoom_valid;
    logic signed [16:0] zoom_low;
    logic signed [16:0] zoom_high;
  } scan_result_t;

  localparam int unsigned ReportLimit = 10;

  // sweep state and register copies
  logic        sweep_on;
  logic [31:0] sweep_t0;
  logic [15:0] sweep_pos;
  logic [12:0] scan_ms;
  logic [4:0]  zoom_f;
  logic [9:0]  lag_ms;

  scan_result_t owed_results[$];
  int unsigned  n_bad;

  // elapsed * 4096 / scan time, saturated to 16 bits
  function automatic logic [15:0] sweep_quotient(input logic [31:0] elapsed);
    logic [63:0] q;
    if (scan_ms == '0) return QuotMax;
    q = (64'(elapsed) << 12) / 64'(scan_ms);
    return (q > 64'(QuotMax)) ? QuotMax : q[15:0];
  endfunction

  // one item applied to the sweep state, giving its result
  task automatic advance_sweep(input logic kind, input logic [31:0] now,
                               output scan_result_t res);
    logic [31:0] elapsed;
    logic [15:0] q;
    int          z;
    int          span;
    int          lo;
    int          hi;
    res     = '0;
    lo      = 0;
    hi      = 0;
    elapsed = now - sweep_t0;
    if (kind == KindTick) begin
      if (sweep_on) begin
        q = sweep_quotient(elapsed);
        if (q > PosTurn) begin
          if (q > PosStop) sweep_on = 1'b0;
          sweep_pos = '0;
        end else if (q > PosQuarter) begin
          sweep_pos = PosTurn - q;
        end else begin
          sweep_pos = q;
        end
      end
    end else if (sweep_on) begin
      // press time minus reaction lag, clamped at zero
      q = sweep_quotient((elapsed > 32'(lag_ms)) ? elapsed - 32'(lag_ms) : 32'd0);
      z = (zoom_f == '0) ? 1 : (zoom_f > 5'd16) ? 16 : int'(zoom_f);
      if (q > PosTurn) begin
        // zoom out around the middle
        span      = z * int'(ZoomHalf);
        lo        = int'(ZoomHalf) - span;
        hi        = int'(ZoomHalf) + span;
        sweep_pos = '0;
      end else begin
        // zoom in around the folded point
        if (q > PosQuarter) q = PosTurn - q;
        span      = int'(ZoomHalf) / z;
        lo        = int'(q) - span;
        hi        = int'(q) + span;
        sweep_pos = q;
      end
      res.zoom_valid = 1'b1;
      sweep_on       = 1'b0;
    end else begin
      sweep_on = 1'b1;
      sweep_t0 = now;
    end
    res.scanning  = sweep_on;
    res.marker    = sweep_pos[12:0];
    res.zoom_low  = 17'(lo);
    res.zoom_high = 17'(hi);
  endtask

  task automatic check_field(input string name, input integer got, input integer want);
    if (got !== want) begin
      n_bad++;
      if (n_bad <= ReportLimit) begin
        $display("%0t mismatch in %s: expected %0d, got %0d", $time, name, want, got);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    scan_result_t want;
    if (!rst_ni) begin
      sweep_on  = 1'b0;
      sweep_t0  = '0;
      sweep_pos = '0;
      scan_ms   = 13'd100;
      zoom_f    = 5'd1;
      lag_ms    = 10'd25;
      n_bad     = 0;
      owed_results.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // register write
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.wr_index)
          CfgScanTime:  scan_ms = cfg_i.wr_data;
          CfgZoom:      zoom_f = cfg_i.wr_data[4:0];
          CfgButtonLag: lag_ms = cfg_i.wr_data[9:0];
          default: ;
        endcase
      end
      // item transfer
      if (item_i.valid && item_i.ready) begin
        advance_sweep(item_i.kind, item_i.time_ms, want);
        owed_results.push_back(want);
      end
      // result transfer
      if (result_i.valid && result_i.ready) begin
        if (owed_results.size() == 0) begin
          n_bad++;
          if (n_bad <= ReportLimit) begin
            $display("%0t result transfer with nothing outstanding", $time);
          end
        end else begin
          want = owed_results.pop_front();
          check_field("scanning", result_i.scanning, want.scanning);
          check_field("marker_location", result_i.marker_location, want.marker);
          check_field("zoom_valid", result_i.zoom_valid, want.zoom_valid);
          check_field("zoom_low", result_i.zoom_low, want.zoom_low);
          check_field("zoom_high", result_i.zoom_high, want.zoom_high);
        end
      end
      fail_count_o <= n_bad;
      pending_o    <= owed_results.size();
    end
  end

endmodule

// ===== tb/tb_one_button_scan_zoom_top.sv =====
`timescale 1ns / 1ps

module tb_one_button_scan_zoom_top;
  import obsz_pkg::*;

  localparam int unsigned CycleLimit    = 2_000_000;
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned NumPhases     = 13;
  localparam int unsigned ItemsPerPhase = 108;

  logic clk_i;
  logic rst_ni;

  obsz_in_if  in_if ();
  obsz_out_if res_if ();
  obsz_cfg_if cfg_if ();

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned cycle_count = 0;
  int unsigned item_count = 0;
  int unsigned scan_set = 100;
  int unsigned lag_set = 25;
  logic [31:0] cur_ms = '0;
  logic        calm = 1'b0;

  one_button_scan_zoom_top i_dut (
    .clk_i,
    .rst_ni,
    .in_i  (in_if),
    .out_o (res_if),
    .cfg_i (cfg_if)
  );

  obsz_checker i_checker (
    .clk_i,
    .rst_ni,
    .item_i       (in_if),
    .result_i     (res_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // idle length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(30, 120);
  endfunction

  // ms after sweep start for a given position
  function automatic logic [31:0] ms_for(input int unsigned pos);
    if (scan_set == 0) return $urandom_range(0, 400);
    return (pos * scan_set) / 4096 + $urandom_range(0, 1);
  endfunction

  // result side back-pressure
  initial begin
    int unsigned len;
    res_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      res_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      len = calm ? 0 : idle_len();
      if (len > 0) begin
        res_if.ready <= 1'b0;
        repeat (len) @(posedge clk_i);
      end
    end
  end

  // one item transfer, with a random gap ahead of it
  task automatic send_item(input logic kind, input logic [31:0] at_ms);
    int unsigned gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.kind    <= kind;
    in_if.time_ms <= at_ms;
    do @(posedge clk_i); while (!in_if.ready);
    item_count++;
  endtask

  // wait for the block to drain, then write all three registers
  task automatic load_settings(input int unsigned scan, input int unsigned zoom,
                               input int unsigned lag);
    logic [12:0]         vals [3];
    logic [CfgIdxW-1:0]  idxs [3];
    vals = '{13'(scan), {8'($urandom), 5'(zoom)}, {3'($urandom), 10'(lag)}};
    idxs = '{CfgScanTime, CfgZoom, CfgButtonLag};
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    for (int i = 0; i < 3; i++) begin
      cfg_if.valid    <= 1'b1;
      cfg_if.wr_index <= idxs[i];
      cfg_if.wr_data  <= vals[i];
      do @(posedge clk_i); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
    scan_set = 32'(13'(scan));
    lag_set  = 32'(10'(lag));
  endtask

  // start, a few ticks, usually a selecting press, now and then some noise
  task automatic run_sweep();
    int unsigned n_ticks;
    int unsigned pos;
    logic [31:0] t0;
    logic [31:0] lag_part;
    // a tick far past any running sweep stops it
    cur_ms += 32'h4000_0000 + $urandom_range(0, 65535);
    send_item(KindTick, cur_ms);
    cur_ms += $urandom_range(1, 64);
    t0 = cur_ms;
    send_item(KindPress, t0);
    n_ticks = $urandom_range(0, 6);
    pos = 0;
    repeat (n_ticks) begin
      pos += $urandom_range(0, 2200);
      send_item(KindTick, t0 + ms_for(pos));
    end
    if ($urandom_range(0, 9) < 8) begin
      pos = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 14000)
                                        : pos + $urandom_range(0, 1500);
      lag_part = ($urandom_range(0, 9) == 0) ? $urandom_range(0, lag_set) : lag_set;
      send_item(KindPress, t0 + lag_part + ms_for(pos));
    end
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        send_item(1'($urandom_range(0, 1)),
                  $urandom_range(0, 1) ? $urandom : cur_ms + $urandom_range(0, 30000));
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    logic [32:0] script [25];
    int unsigned scan_tab [5];
    int unsigned zoom_tab [5];
    int unsigned lag_tab [5];
    int unsigned phase_start;
    in_if.valid     = 1'b0;
    in_if.kind      = KindTick;
    in_if.time_ms   = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.wr_index = CfgScanTime;
    cfg_if.wr_data  = '0;
    rst_ni          = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed items at reset settings: scan 100, zoom 1, lag 25
    script = '{
      {KindTick, 32'h0000_0000}, {KindTick, 32'hFFFF_FFFF},
      // sweep started just before the time wraps
      {KindPress, 32'hFFFF_FFF0}, {KindTick, 32'h0000_0010},
      {KindTick, 32'h0000_0054}, {KindTick, 32'h0000_0055},
      {KindTick, 32'h0000_00B8}, {KindTick, 32'h0000_00B9},
      {KindTick, 32'h0000_011C}, {KindTick, 32'h0000_011D},
      {KindTick, 32'h0000_011E},
      // press inside the lag clamps to zero
      {KindPress, 32'd1000}, {KindPress, 32'd1010},
      {KindPress, 32'd2000}, {KindPress, 32'd2075},
      {KindPress, 32'd3000}, {KindPress, 32'd3175},
      // exactly at the turn, then just past it
      {KindPress, 32'd4000}, {KindPress, 32'd4225},
      {KindPress, 32'd5000}, {KindPress, 32'd5226},
      // saturated quotient
      {KindPress, 32'd6000}, {KindPress, 32'd6000 + 32'h8000_0000},
      // elapsed equal to the lag
      {KindPress, 32'd7000}, {KindPress, 32'd7025}
    };
    foreach (script[i]) send_item(script[i][32], script[i][31:0]);

    // settings extremes first, random ones after
    scan_tab = '{100, 5000, 0, 8191, 1};
    zoom_tab = '{16, 1, 0, 31, 17};
    lag_tab  = '{0, 1000, 25, 1023, 512};
    cur_ms   = $urandom;
    for (int unsigned ph = 1; ph <= NumPhases; ph++) begin
      if (ph <= 5) begin
        load_settings(scan_tab[ph-1], zoom_tab[ph-1], lag_tab[ph-1]);
      end else if ($urandom_range(0, 4) == 0) begin
        load_settings($urandom_range(0, 8191), $urandom_range(0, 31), $urandom_range(0, 1023));
      end else begin
        load_settings($urandom_range(100, 5000), $urandom_range(1, 16),
                      $urandom_range(0, 1000));
      end
      calm = (ph % 4 == 2);
      phase_start = item_count;
      while (item_count - phase_start < ItemsPerPhase) run_sweep();
    end
    calm = 1'b0;

    // drain
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
